### src/jst_pkg.sv
// Shared types for the JSON stream tokenizer: parse states, contexts, result codes and structs.
package jst_pkg;

   typedef enum logic [1:0] {
      MODE_TEXT    = 2'd0,
      MODE_RESTART = 2'd1,
      MODE_STATUS  = 2'd2,
      MODE_NOP     = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_AWAIT_KEY   = 4'd0,
      ST_AWAIT_COLON = 4'd2,
      ST_AWAIT_VALUE = 4'd3,
      ST_IN_TOKEN    = 4'd7,
      ST_AWAIT_COMMA = 4'd8,
      ST_IN_STRING   = 4'd9,
      ST_IN_ESCAPE   = 4'd10,
      ST_IN_HEX      = 4'd11
   } state_type;

   typedef enum logic [1:0] {
      CX_OBJ = 2'd0,
      CX_ARR = 2'd1,
      CX_KEY = 2'd2,
      CX_STR = 2'd3
   } ctx_type;

   typedef enum logic [3:0] {
      K_CHAR      = 4'd0,
      K_OBJ_OPEN  = 4'd1,
      K_OBJ_CLOSE = 4'd2,
      K_ARR_OPEN  = 4'd3,
      K_ARR_CLOSE = 4'd4,
      K_KEY       = 4'd5,
      K_STRING    = 4'd6,
      K_TOKEN     = 4'd7,
      K_ERROR     = 4'd8,
      K_STATUS    = 4'd9
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE       = 4'd0,
      ERR_STACK_FULL = 4'd1,
      ERR_KEY_EXP    = 4'd2,
      ERR_COLON_EXP  = 4'd3,
      ERR_OBJ_CLOSE  = 4'd4,
      ERR_ARR_CLOSE  = 4'd5,
      ERR_COMMA      = 4'd6,
      ERR_STR_END    = 4'd7,
      ERR_OVERFLOW   = 4'd8
   } err_type;

   // one result item
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  char_byte;
      logic [5:0]  text_length;
      err_type     error_code;
      logic [5:0]  depth;
      logic        last;
   } ev_type;

   // parse state other than the text count
   typedef struct packed {
      state_type   st;
      logic [2:0]  hex_seen;
      logic [7:0]  hex_value;
      err_type     fault;
   } pstate_type;

   typedef struct packed {
      logic        clear;
      logic        push;
      logic        pop;
      ctx_type     ctx;
   } stk_op_type;

endpackage

### src/jst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jst_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/jst_stack.sv
// Context stack: top and next entries in registers, deeper entries in RAM.
module jst_stack import jst_pkg::*; #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             apply,
   input  stk_op_type                       op,
   output logic [$clog2(STACK_DEPTH+1)-1:0] count,
   output ctx_type                          top
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int AW    = $clog2(STACK_DEPTH);

   logic [CNT_W-1:0] count_ff, count_in;
   ctx_type          top_ff, top_in;
   ctx_type          below_ff, below_in;
   logic             byp_ff, byp_in;
   ctx_type          byp_data_ff;
   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [1:0]       rd_data;
   ctx_type          deep;

   // entry below the next one: RAM data, or what was written on the last cycle
   assign deep = byp_ff ? byp_data_ff : ctx_type'(rd_data);

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      below_in = below_ff;
      wr_en    = 1'b0;
      if (apply) begin
         if (op.clear) begin
            count_in = '0;
         end else if (op.push) begin
            wr_en    = (count_ff >= CNT_W'(2));
            below_in = top_ff;
            top_in   = op.ctx;
            count_in = count_ff + CNT_W'(1);
         end else if (op.pop) begin
            top_in   = below_ff;
            below_in = deep;
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   assign wr_addr = AW'(count_ff - CNT_W'(2));
   assign rd_addr = AW'(count_in - CNT_W'(3));
   assign byp_in  = wr_en;

   jst_ram #(
      .WIDTH (2),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (below_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         byp_ff   <= byp_in;
      end
      top_ff      <= top_in;
      below_ff    <= below_in;
      byp_data_ff <= below_ff;
   end

   assign count = count_ff;
   assign top   = top_ff;

endmodule

### src/jst_decode.sv
// Byte decoder: next parse state, stack operation and up to two result items per byte.
module jst_decode import jst_pkg::*; #(
   parameter int STACK_DEPTH = 32,
   parameter int TEXT_LIMIT  = 64
) (
   input  logic [1:0]                       mode,
   input  logic [7:0]                       text_byte,
   input  pstate_type                       pst,
   input  logic [$clog2(TEXT_LIMIT)-1:0]    tc,
   input  logic [$clog2(STACK_DEPTH+1)-1:0] stk_count,
   input  ctx_type                          stk_top,
   output pstate_type                       pst_n,
   output logic [$clog2(TEXT_LIMIT)-1:0]    tc_n,
   output stk_op_type                       op,
   output logic [1:0]                       ev_cnt,
   output ev_type                           ev0,
   output ev_type                           ev1
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int TC_W  = $clog2(TEXT_LIMIT);

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] ESC_B     = 8'h62;
   localparam logic [7:0] ESC_F     = 8'h66;
   localparam logic [7:0] ESC_N     = 8'h6E;
   localparam logic [7:0] ESC_R     = 8'h72;
   localparam logic [7:0] ESC_T     = 8'h74;
   localparam logic [7:0] ESC_U     = 8'h75;

   function automatic ev_type mk_ev(kind_type k, logic [7:0] c, logic [5:0] l,
                                    err_type e, logic [5:0] d);
      ev_type r;
      r.kind        = k;
      r.char_byte   = c;
      r.text_length = l;
      r.error_code  = e;
      r.depth       = d;
      r.last        = 1'b0;
      return r;
   endfunction

   // {is hex digit, value}
   function automatic logic [4:0] hex_digit(logic [7:0] b);
      logic [4:0] r;
      r = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   ev_type           ev [2];
   logic [1:0]       cnt;
   logic [5:0]       dep6;
   logic             top_obj, top_arr, top_key, top_str, full;
   logic             room_char, room_hex;
   logic [TC_W-1:0]  tc_cur;
   logic [4:0]       hexd;
   logic [7:0]       hv_new;
   logic [2:0]       hs_new;
   logic             do_comma, do_str;
   logic [7:0]       b;

   assign b       = text_byte;
   assign dep6    = 6'(stk_count);
   assign top_obj = (stk_count != '0) && (stk_top == CX_OBJ);
   assign top_arr = (stk_count != '0) && (stk_top == CX_ARR);
   assign top_key = (stk_count != '0) && (stk_top == CX_KEY);
   assign top_str = (stk_count != '0) && (stk_top == CX_STR);
   assign full    = (stk_count == CNT_W'(STACK_DEPTH));
   assign room_char = (tc < TC_W'(TEXT_LIMIT - 1));
   assign room_hex  = ((TC_W+1)'(tc) + (TC_W+1)'(2)) < (TC_W+1)'(TEXT_LIMIT);
   assign hexd    = hex_digit(b);
   assign hv_new  = {pst.hex_value[3:0], hexd[3:0]};
   assign hs_new  = pst.hex_seen + 3'd1;

   always_comb begin
      pst_n    = pst;
      tc_n     = tc;
      op       = '0;
      op.ctx   = CX_OBJ;
      ev[0]    = '0;
      ev[1]    = '0;
      cnt      = 2'd0;
      tc_cur   = tc;
      do_comma = 1'b0;
      do_str   = 1'b0;

      unique case (mode)
         MODE_RESTART: begin
            pst_n.st        = ST_AWAIT_VALUE;
            pst_n.hex_seen  = '0;
            pst_n.hex_value = '0;
            pst_n.fault     = ERR_NONE;
            tc_n            = '0;
            op.clear        = 1'b1;
         end
         MODE_STATUS: begin
            ev[cnt[0]] = mk_ev(K_STATUS, 8'd0, 6'd0, pst.fault, dep6);
            cnt = cnt + 2'd1;
         end
         MODE_TEXT: begin
            if (pst.fault == ERR_NONE && b >= CH_SPACE && b != CH_DEL &&
                !(b == CH_SPACE && pst.st != ST_IN_STRING && pst.st != ST_IN_HEX)) begin
               unique case (pst.st)
                  ST_AWAIT_KEY: begin
                     if (b == CH_QUOTE) begin
                        if (full) begin
                           pst_n.fault = ERR_STACK_FULL;
                           ev[cnt[0]] = mk_ev(K_ERROR, 8'd0, 6'd0, ERR_STACK_FULL, dep6);
                           cnt = cnt + 2'd1;
                        end else begin
                           op.push  = 1'b1;
                           op.ctx   = CX_KEY;
                           tc_n     = '0;
                           pst_n.st = ST_IN_STRING;
                        end
                     end else if (b == CH_RBRACE) begin
                        do_comma = 1'b1;
                     end else begin
                        pst_n.fault = ERR_KEY_EXP;
                        ev[cnt[0]] = mk_ev(K_ERROR, 8'd0, 6'd0, ERR_KEY_EXP, dep6);
                        cnt = cnt + 2'd1;
                     end
                  end
                  ST_AWAIT_COLON: begin
                     if (b == CH_COLON) begin
                        pst_n.st = ST_AWAIT_VALUE;
                     end else begin
                        pst_n.fault = ERR_COLON_EXP;
                        ev[cnt[0]] = mk_ev(K_ERROR, 8'd0, 6'd0, ERR_COLON_EXP, dep6);
                        cnt = cnt + 2'd1;
                     end
                  end
                  ST_AWAIT_VALUE: begin
                     if (b == CH_LBRACE || b == CH_LBRACK || b == CH_QUOTE) begin
                        if (b == CH_LBRACE) begin
                           ev[cnt[0]] = mk_ev(K_OBJ_OPEN, 8'd0, 6'd0, ERR_NONE, 6'd0);
                           cnt = cnt + 2'd1;
                        end else if (b == CH_LBRACK) begin
                           ev[cnt[0]] = mk_ev(K_ARR_OPEN, 8'd0, 6'd0, ERR_NONE, 6'd0);
                           cnt = cnt + 2'd1;
                        end
                        if (full) begin
                           pst_n.fault = ERR_STACK_FULL;
                           ev[cnt[0]] = mk_ev(K_ERROR, 8'd0, 6'd0, ERR_STACK_FULL, dep6);
                           cnt = cnt + 2'd1;
                        end else begin
                           op.push = 1'b1;
                           if (b == CH_LBRACE) begin
                              op.ctx   = CX_OBJ;
                              pst_n.st = ST_AWAIT_KEY;
                           end else if (b == CH_LBRACK) begin
                              op.ctx   = CX_ARR;
                              pst_n.st = ST_AWAIT_VALUE;
                           end else begin
                              op.ctx   = CX_STR;
                              tc_n     = '0;
                              pst_n.st = ST_IN_STRING;
                           end
                        end
                     end else if (b == CH_RBRACK) begin
                        do_comma = 1'b1;
                     end else if (b == CH_RBRACE || b == CH_COMMA) begin
                        // empty token, then the delimiter
                        tc_n     = '0;
                        pst_n.st = ST_AWAIT_COMMA;
                        ev[cnt[0]] = mk_ev(K_TOKEN, 8'd0, 6'd0, ERR_NONE, 6'd0);
                        cnt = cnt + 2'd1;
                        do_comma = 1'b1;
                     end else begin
                        pst_n.st = ST_IN_TOKEN;
                        tc_n     = TC_W'(1);
                        ev[cnt[0]] = mk_ev(K_CHAR, b, 6'd0, ERR_NONE, 6'd0);
                        cnt = cnt + 2'd1;
                     end
                  end
                  ST_IN_TOKEN: begin
                     if (b == CH_RBRACE || b == CH_RBRACK || b == CH_COMMA) begin
                        pst_n.st = ST_AWAIT_COMMA;
                        ev[cnt[0]] = mk_ev(K_TOKEN, 8'd0, 6'(tc), ERR_NONE, 6'd0);
                        cnt = cnt + 2'd1;
                        do_comma = 1'b1;
                     end else if (!room_char) begin
                        pst_n.fault = ERR_OVERFLOW;
                        ev[cnt[0]] = mk_ev(K_ERROR, 8'd0, 6'd0, ERR_OVERFLOW, dep6);
                        cnt = cnt + 2'd1;
                     end else begin
                        tc_n = tc + TC_W'(1);
                        ev[cnt[0]] = mk_ev(K_CHAR, b, 6'd0, ERR_NONE, 6'd0);
                        cnt = cnt + 2'd1;
                     end
                  end
                  ST_AWAIT_COMMA: begin
                     do_comma = 1'b1;
                  end
                  ST_IN_STRING: begin
                     do_str = 1'b1;
                  end
                  ST_IN_ESCAPE: begin
                     pst_n.st = ST_IN_STRING;
                     if (b == ESC_U) begin
                        if (!room_hex) begin
                           pst_n.fault = ERR_OVERFLOW;
                           ev[cnt[0]] = mk_ev(K_ERROR, 8'd0, 6'd0, ERR_OVERFLOW, dep6);
                           cnt = cnt + 2'd1;
                        end else begin
                           pst_n.hex_seen  = '0;
                           pst_n.hex_value = '0;
                           pst_n.st        = ST_IN_HEX;
                        end
                     end else begin
                        tc_n = tc + TC_W'(1);
                        unique case (b)
                           ESC_B:   ev[cnt[0]] = mk_ev(K_CHAR, CH_BS, 6'd0, ERR_NONE, 6'd0);
                           ESC_F:   ev[cnt[0]] = mk_ev(K_CHAR, CH_FF, 6'd0, ERR_NONE, 6'd0);
                           ESC_N:   ev[cnt[0]] = mk_ev(K_CHAR, CH_LF, 6'd0, ERR_NONE, 6'd0);
                           ESC_R:   ev[cnt[0]] = mk_ev(K_CHAR, CH_CR, 6'd0, ERR_NONE, 6'd0);
                           ESC_T:   ev[cnt[0]] = mk_ev(K_CHAR, CH_TAB, 6'd0, ERR_NONE, 6'd0);
                           default: ev[cnt[0]] = mk_ev(K_CHAR, b, 6'd0, ERR_NONE, 6'd0);
                        endcase
                        cnt = cnt + 2'd1;
                     end
                  end
                  ST_IN_HEX: begin
                     if (hexd[4]) begin
                        pst_n.hex_value = hv_new;
                        pst_n.hex_seen  = hs_new;
                        if (hs_new >= 3'd4) begin
                           tc_n     = tc + TC_W'(1);
                           pst_n.st = ST_IN_STRING;
                           ev[cnt[0]] = mk_ev(K_CHAR, hv_new, 6'd0, ERR_NONE, 6'd0);
                           cnt = cnt + 2'd1;
                        end
                     end else begin
                        // short escape: emit what was gathered, then treat the byte as text
                        tc_cur   = tc + TC_W'(1);
                        tc_n     = tc_cur;
                        pst_n.st = ST_IN_STRING;
                        ev[cnt[0]] = mk_ev(K_CHAR, pst.hex_value, 6'd0, ERR_NONE, 6'd0);
                        cnt = cnt + 2'd1;
                        do_str = 1'b1;
                     end
                  end
                  default: begin
                     pst_n.st = ST_AWAIT_VALUE;
                  end
               endcase

               if (do_comma) begin
                  priority if (b == CH_RBRACE) begin
                     if (top_obj) begin
                        op.pop   = 1'b1;
                        pst_n.st = ST_AWAIT_COMMA;
                        ev[cnt[0]] = mk_ev(K_OBJ_CLOSE, 8'd0, 6'd0, ERR_NONE, 6'd0);
                        cnt = cnt + 2'd1;
                     end else begin
                        pst_n.fault = ERR_OBJ_CLOSE;
                        ev[cnt[0]] = mk_ev(K_ERROR, 8'd0, 6'd0, ERR_OBJ_CLOSE, dep6);
                        cnt = cnt + 2'd1;
                     end
                  end else if (b == CH_RBRACK) begin
                     if (top_arr) begin
                        op.pop   = 1'b1;
                        pst_n.st = ST_AWAIT_COMMA;
                        ev[cnt[0]] = mk_ev(K_ARR_CLOSE, 8'd0, 6'd0, ERR_NONE, 6'd0);
                        cnt = cnt + 2'd1;
                     end else begin
                        pst_n.fault = ERR_ARR_CLOSE;
                        ev[cnt[0]] = mk_ev(K_ERROR, 8'd0, 6'd0, ERR_ARR_CLOSE, dep6);
                        cnt = cnt + 2'd1;
                     end
                  end else if (b == CH_COMMA) begin
                     if (top_obj) begin
                        pst_n.st = ST_AWAIT_KEY;
                     end else if (top_arr) begin
                        pst_n.st = ST_AWAIT_VALUE;
                     end else begin
                        pst_n.fault = ERR_COMMA;
                        ev[cnt[0]] = mk_ev(K_ERROR, 8'd0, 6'd0, ERR_COMMA, dep6);
                        cnt = cnt + 2'd1;
                     end
                  end else begin
                     // stray byte after a value
                     pst_n.st = pst.st;
                  end
               end

               if (do_str) begin
                  priority if (b == CH_QUOTE) begin
                     if (top_key) begin
                        op.pop   = 1'b1;
                        pst_n.st = ST_AWAIT_COLON;
                        ev[cnt[0]] = mk_ev(K_KEY, 8'd0, 6'(tc_cur), ERR_NONE, 6'd0);
                        cnt = cnt + 2'd1;
                     end else if (top_str) begin
                        op.pop   = 1'b1;
                        pst_n.st = ST_AWAIT_COMMA;
                        ev[cnt[0]] = mk_ev(K_STRING, 8'd0, 6'(tc_cur), ERR_NONE, 6'd0);
                        cnt = cnt + 2'd1;
                     end else begin
                        pst_n.fault = ERR_STR_END;
                        ev[cnt[0]] = mk_ev(K_ERROR, 8'd0, 6'd0, ERR_STR_END, dep6);
                        cnt = cnt + 2'd1;
                     end
                  end else if (tc_cur >= TC_W'(TEXT_LIMIT - 1)) begin
                     pst_n.fault = ERR_OVERFLOW;
                     ev[cnt[0]] = mk_ev(K_ERROR, 8'd0, 6'd0, ERR_OVERFLOW, dep6);
                     cnt = cnt + 2'd1;
                  end else if (b == CH_BSLASH) begin
                     pst_n.st = ST_IN_ESCAPE;
                  end else begin
                     tc_n = tc_cur + TC_W'(1);
                     ev[cnt[0]] = mk_ev(K_CHAR, b, 6'd0, ERR_NONE, 6'd0);
                     cnt = cnt + 2'd1;
                  end
               end
            end
         end
         default: begin
            pst_n = pst;
         end
      endcase

      if (cnt == 2'd1) begin
         ev[0].last = 1'b1;
      end else if (cnt == 2'd2) begin
         ev[1].last = 1'b1;
      end
   end

   assign ev_cnt = cnt;
   assign ev0    = ev[0];
   assign ev1    = ev[1];

endmodule

### src/jst_rsp_buf.sv
// Result buffer: holds the up to two result items of one byte and presents them in order.
module jst_rsp_buf import jst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic [1:0] ev_cnt,
   input  ev_type     ev0,
   input  ev_type     ev1,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output ev_type     rsp_ev
);

   logic [1:0] cnt_ff, cnt_in;
   ev_type     slot0_ff, slot0_in;
   ev_type     slot1_ff, slot1_in;
   logic       pop;

   assign pop  = (cnt_ff != 2'd0) && !rsp_stall;
   assign free = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && !rsp_stall);

   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         cnt_in   = ev_cnt;
         slot0_in = ev0;
         slot1_in = ev1;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_ev    = slot0_ff;

endmodule

### src/json_stream_tokenizer_unit.sv
// Top level of the JSON stream tokenizer: input register, parse state and result buffer.
//
//   channel  ports                                   direction  transfer when
//   req      req_valid req_stall req_mode            in         req_valid && !req_stall
//            req_text_byte
//   rsp      rsp_valid rsp_stall rsp_kind            out        rsp_valid && !rsp_stall
//            rsp_char_byte rsp_text_length
//            rsp_error_code rsp_depth rsp_last
//
// One byte per cycle unless stalled; a byte with two results stalls input until both are taken.
// A byte passes the input register and the decoder; its results are registered in the result buffer.
// The per-byte step is one pass of the decoder against the registered stack top.
// Synchronous reset; no clearing pass, the stack is only read below its count.
// req_stall rises while the input register holds a byte the result buffer cannot yet take.
module json_stream_tokenizer_unit import jst_pkg::*; #(
   parameter int STACK_DEPTH = 32,
   parameter int TEXT_LIMIT  = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_kind,
   output logic [7:0] rsp_char_byte,
   output logic [5:0] rsp_text_length,
   output logic [3:0] rsp_error_code,
   output logic [5:0] rsp_depth,
   output logic       rsp_last
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int TC_W  = $clog2(TEXT_LIMIT);

   logic             in_valid_ff, in_valid_in;
   logic [1:0]       mode_ff;
   logic [7:0]       byte_ff;
   logic             accept, advance, free;

   pstate_type       pst_ff, pst_in;
   logic [TC_W-1:0]  tc_ff, tc_in;
   stk_op_type       op;
   logic [CNT_W-1:0] stk_count;
   ctx_type          stk_top;
   logic [1:0]       ev_cnt;
   ev_type           ev0, ev1, rsp_ev;

   assign advance   = in_valid_ff && free;
   assign req_stall = in_valid_ff && !free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         pst_ff.st        <= ST_AWAIT_VALUE;
         pst_ff.hex_seen  <= '0;
         pst_ff.hex_value <= '0;
         pst_ff.fault     <= ERR_NONE;
         tc_ff            <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            pst_ff <= pst_in;
            tc_ff  <= tc_in;
         end
      end
      if (accept) begin
         mode_ff <= req_mode;
         byte_ff <= req_text_byte;
      end
   end

   jst_decode #(
      .STACK_DEPTH (STACK_DEPTH),
      .TEXT_LIMIT  (TEXT_LIMIT)
   ) u_decode (
      .mode      (mode_ff),
      .text_byte (byte_ff),
      .pst       (pst_ff),
      .tc        (tc_ff),
      .stk_count (stk_count),
      .stk_top   (stk_top),
      .pst_n     (pst_in),
      .tc_n      (tc_in),
      .op        (op),
      .ev_cnt    (ev_cnt),
      .ev0       (ev0),
      .ev1       (ev1)
   );

   jst_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .apply (advance),
      .op    (op),
      .count (stk_count),
      .top   (stk_top)
   );

   jst_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .ev_cnt    (ev_cnt),
      .ev0       (ev0),
      .ev1       (ev1),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_ev    (rsp_ev)
   );

   assign rsp_kind        = rsp_ev.kind;
   assign rsp_char_byte   = rsp_ev.char_byte;
   assign rsp_text_length = rsp_ev.text_length;
   assign rsp_error_code  = rsp_ev.error_code;
   assign rsp_depth       = rsp_ev.depth;
   assign rsp_last        = rsp_ev.last;

endmodule
